// ===== sv/ffbl_pkg.sv =====
// types and constants shared by the free block list allocator
package ffbl_pkg;

  localparam int RESERVE_UNIT = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  localparam logic [2:0] CMD_ALLOC       = 3'd0;
  localparam logic [2:0] CMD_ALLOC_GC    = 3'd1;
  localparam logic [2:0] CMD_ALLOC_CHIP  = 3'd2;
  localparam logic [2:0] CMD_ALLOC_UNCHK = 3'd3;
  localparam logic [2:0] CMD_RELEASE     = 3'd4;
  localparam logic [2:0] CMD_PEEK        = 3'd5;
  localparam logic [2:0] CMD_PEEK_CHIP   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVE_TOTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE_PER_CHIP = 2'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [9:0] blk_num;
    logic [1:0] chip_id;
  } ffbl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  block_out;
    logic [10:0] free_total_out;
    logic [8:0]  free_chip_out;
  } ffbl_out_t;

endpackage

// ===== sv/flash_free_block_list.sv =====
// flash free block allocator: linked fifo of free blocks with reserve checks
// peek and refused or bad commands go straight to the result state
// alloc pops the head; release pushes to the tail unless already listed
// chip alloc pushes each popped block of another chip back to the tail
// one command at a time, set by the single link ram port sequence
// synchronous reset, then a clearing pass over all blocks builds the chain
module flash_free_block_list
  import ffbl_pkg::*;
#(
  parameter int NUM_BLOCKS      = 1024,
  parameter int NUM_CHIPS       = 4,
  parameter int BLOCKS_PER_CHIP = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ffbl_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ffbl_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW  = $clog2(NUM_BLOCKS);
  localparam int LW  = $clog2(NUM_BLOCKS + 2);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int CHW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam logic [LW-1:0] LINK_END = LW'(NUM_BLOCKS);
  localparam logic [LW-1:0] LINK_OUT = LW'(NUM_BLOCKS + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_PUSH_A = 3'd4;
  localparam logic [2:0] S_PUSH_B = 3'd5;
  localparam logic [2:0] S_REL    = 3'd6;
  localparam logic [2:0] S_RES    = 3'd7;

  function automatic logic [CHW-1:0] chip_of(input logic [IW-1:0] blk);
    logic [CHW-1:0] c;
    c = '0;
    for (int i = 1; i < NUM_CHIPS; i++) begin
      if (32'(blk) >= i * BLOCKS_PER_CHIP) c = CHW'(i);
    end
    return c;
  endfunction

  function automatic int chip_count(input int c);
    int lo;
    int hi;
    lo = c * BLOCKS_PER_CHIP;
    hi = (c + 1) * BLOCKS_PER_CHIP;
    if (hi > NUM_BLOCKS || c == NUM_CHIPS - 1) hi = NUM_BLOCKS;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  logic [2:0]      state;
  logic [IW-1:0]   init_idx;
  logic [IW-1:0]   head;
  logic [IW-1:0]   tail;
  logic [CW-1:0]   free_total;
  logic [CW-1:0]   free_in_chip [NUM_CHIPS];
  logic [10:0]     reserve_total;
  logic [8:0]      reserve_per_chip;
  logic [2:0]      cmd;
  logic [IW-1:0]   bid;
  logic [1:0]      chip;
  logic            chip_ok;
  logic [1:0]      status;
  logic [IW-1:0]   blk;
  logic [IW-1:0]   push_blk;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [LW-1:0]   wdata;
  logic [IW-1:0]   raddr;
  logic [LW-1:0]   rdata;

  logic            accept;
  logic            in_chip_ok;
  logic [CW-1:0]   in_fc;
  logic [CW-1:0]   fc;
  logic            bid_ok;
  logic            pop_match;

  ffbl_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_link (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign in_chip_ok = 32'(in_data.chip_id) < NUM_CHIPS;
  assign in_fc      = in_chip_ok ? free_in_chip[CHW'(in_data.chip_id)] : '0;
  assign fc         = chip_ok ? free_in_chip[CHW'(chip)] : '0;
  assign bid_ok     = 32'(in_data.blk_num) < NUM_BLOCKS;
  assign pop_match  = (cmd != CMD_ALLOC_CHIP && cmd != CMD_ALLOC_UNCHK) ||
                      (32'(chip_of(head)) == 32'(chip));

  always_comb begin
    raddr = head;
    if (state == S_IDLE && in_data.command == CMD_RELEASE) begin
      raddr = IW'(in_data.blk_num);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = init_idx;
    wdata = LW'(init_idx) + LW'(1);
    case (state)
      S_INIT: begin
        we = 1'b1;
      end
      S_POP: begin
        if (pop_match) begin
          we    = 1'b1;
          waddr = head;
          wdata = LINK_OUT;
        end
      end
      S_PUSH_A: begin
        we    = (free_total != '0);
        waddr = tail;
        wdata = LW'(push_blk);
      end
      S_PUSH_B: begin
        we    = 1'b1;
        waddr = push_blk;
        wdata = LINK_END;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_total    <= 11'(RESERVE_UNIT * NUM_CHIPS);
      reserve_per_chip <= 9'(RESERVE_UNIT);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_RESERVE_TOTAL) reserve_total <= cfg_data;
      if (cfg_index == REG_RESERVE_PER_CHIP) reserve_per_chip <= cfg_data[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      head       <= '0;
      tail       <= IW'(NUM_BLOCKS - 1);
      free_total <= CW'(NUM_BLOCKS);
      for (int c = 0; c < NUM_CHIPS; c++) begin
        free_in_chip[c] <= CW'(chip_count(c));
      end
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RES) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          init_idx <= init_idx + IW'(1);
          if (32'(init_idx) == NUM_BLOCKS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cmd     <= in_data.command;
            bid     <= IW'(in_data.blk_num);
            chip    <= in_data.chip_id;
            chip_ok <= in_chip_ok;
            blk     <= '0;
            status  <= ST_ERROR;
            state   <= S_RES;
            case (in_data.command)
              CMD_ALLOC: begin
                if (32'(free_total) > 32'(reserve_total)) state <= S_POP;
                else status <= ST_REFUSED;
              end
              CMD_ALLOC_GC: begin
                if (free_total != '0) state <= S_POP;
              end
              CMD_ALLOC_CHIP, CMD_ALLOC_UNCHK: begin
                if (!in_chip_ok) begin
                  status <= ST_ERROR;
                end else if (in_data.command == CMD_ALLOC_CHIP &&
                             !(32'(in_fc) > 32'(reserve_per_chip))) begin
                  status <= ST_REFUSED;
                end else if (in_fc != '0 && free_total != '0) begin
                  state <= S_POP;
                end
              end
              CMD_RELEASE: begin
                if (bid_ok) state <= S_REL;
              end
              CMD_PEEK: begin
                if (32'(free_total) > 32'(reserve_total)) begin
                  status <= ST_OK;
                  blk    <= head;
                end else begin
                  status <= ST_REFUSED;
                end
              end
              CMD_PEEK_CHIP: begin
                if (in_chip_ok) begin
                  if (32'(in_fc) > 32'(reserve_per_chip)) begin
                    status <= ST_OK;
                    blk    <= head;
                  end else begin
                    status <= ST_REFUSED;
                  end
                end
              end
              default: begin
                status <= ST_ERROR;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_POP;
        end
        S_POP: begin
          if (32'(rdata) < NUM_BLOCKS) head <= IW'(rdata);
          free_total <= free_total - CW'(1);
          free_in_chip[chip_of(head)] <= free_in_chip[chip_of(head)] - CW'(1);
          if (pop_match) begin
            status <= ST_OK;
            blk    <= head;
            state  <= S_RES;
          end else begin
            push_blk <= head;
            state    <= S_PUSH_A;
          end
        end
        S_REL: begin
          if (rdata == LINK_OUT) begin
            push_blk <= bid;
            state    <= S_PUSH_A;
          end else begin
            state <= S_RES;
          end
        end
        S_PUSH_A: begin
          if (free_total == '0) head <= push_blk;
          tail       <= push_blk;
          free_total <= free_total + CW'(1);
          free_in_chip[chip_of(push_blk)] <= free_in_chip[chip_of(push_blk)] + CW'(1);
          state      <= S_PUSH_B;
        end
        S_PUSH_B: begin
          if (cmd == CMD_RELEASE) begin
            status <= ST_OK;
            state  <= S_RES;
          end else begin
            state <= S_RD;
          end
        end
        S_RES: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.status         <= status;
            out_data.block_out      <= (status == ST_OK) ? 10'(blk) : '0;
            out_data.free_total_out <= 11'(free_total);
            out_data.free_chip_out  <= 9'(fc);
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) 32'(free_total) <= NUM_BLOCKS)
    else $error("free count above block count");
  assert property (@(posedge clk) disable iff (rst) state == S_PUSH_A |=> state == S_PUSH_B)
    else $error("push sequence broken");
  assert property (@(posedge clk) disable iff (rst)
    accept && in_data.command == CMD_PEEK |=> state == S_RES)
    else $error("peek did not go straight to result");
  assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> free_total != '0)
    else $error("pop from empty list");
`endif

endmodule

// ===== sv/ffbl_ram.sv =====
// generic single write port ram with registered read
module ffbl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
